// ===== hw/rtl/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

    typedef enum logic [1:0] {
        MODE_TRI   = 2'd0,
        MODE_POINT = 2'd1,
        MODE_LINE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REC_INDEX = 2'd0,
        REC_COPY  = 2'd1,
        REC_RETAG = 2'd2
    } rec_kind_t;

    localparam int MODE_W = 2;
    localparam int MASK_W = 3;
    localparam int POS_W  = 4;
    localparam int TEX_W  = 4;
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] LAST_STEP = 4'd9;

    localparam logic [MASK_W-1:0] TEX_MASK_POINT = 3'd1;
    localparam logic [MASK_W-1:0] TEX_MASK_LINE  = 3'd3;

    localparam logic [TEX_W-1:0] TEX_OFS_NONE = 4'd0;
    localparam logic [TEX_W-1:0] TEX_OFS_XY   = 4'd7;
    localparam logic [TEX_W-1:0] TEX_OFS_X    = TEX_OFS_XY - 4'd2;
    localparam logic [TEX_W-1:0] TEX_OFS_Y    = TEX_OFS_XY - 4'd1;
    localparam logic [TEX_W-1:0] TEX_OFS_LINE = 4'd8;

    localparam logic [POS_W-1:0] POS_CORNER_LT = 4'd5;
    localparam logic [POS_W-1:0] POS_CORNER_RT = POS_CORNER_LT + 4'd1;
    localparam logic [POS_W-1:0] POS_CORNER_LB = POS_CORNER_LT + 4'd2;
    localparam logic [POS_W-1:0] POS_CORNER_RB = 4'd8;
    localparam logic [POS_W-1:0] POS_DIR_NEG_X = 4'd9;
    localparam logic [POS_W-1:0] POS_DIR_POS_X = POS_DIR_NEG_X + 4'd1;
    localparam logic [POS_W-1:0] POS_DIR_POS_Y = 4'd12;
    localparam logic [POS_W-1:0] POS_DIR_NEG_Y = POS_DIR_POS_Y - 4'd1;

    // queue entry: {mode, t0, t1, a, b, c}
    function automatic int ent_width(input int iw);
        return MODE_W + 2 * POS_W + 3 * iw;
    endfunction

endpackage

// ===== hw/rtl/ple_prim_if.sv =====
`timescale 1ns / 1ps

interface ple_prim_if #(
    parameter int INDEX_WIDTH = 16,
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic                          batch_start;
    logic [INDEX_WIDTH-1:0]        new_vertex_base;
    logic [INDEX_WIDTH-1:0]        vert_a;
    logic [INDEX_WIDTH-1:0]        vert_b;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;

    modport source (
        output valid, mode, batch_start, new_vertex_base, vert_a, vert_b,
               first_x, first_y, second_x, second_y,
        input  ready
    );

    modport sink (
        input  valid, mode, batch_start, new_vertex_base, vert_a, vert_b,
               first_x, first_y, second_x, second_y,
        output ready
    );
endinterface

// ===== hw/rtl/ple_rec_if.sv =====
`timescale 1ns / 1ps

interface ple_rec_if #(
    parameter int INDEX_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             record_kind;
    logic [INDEX_WIDTH-1:0] vertex_index;
    logic [INDEX_WIDTH-1:0] source_index;
    logic [2:0]             tex_mask_tag;
    logic [3:0]             position_tag;
    logic [3:0]             tex_offset_tag;
    logic                   last;

    modport source (
        output valid, record_kind, vertex_index, source_index, tex_mask_tag,
               position_tag, tex_offset_tag, last,
        input  ready
    );

    modport sink (
        input  valid, record_kind, vertex_index, source_index, tex_mask_tag,
               position_tag, tex_offset_tag, last,
        output ready
    );
endinterface

// ===== hw/rtl/ple_front.sv =====
`timescale 1ns / 1ps

module ple_front
    import ple_pkg::*;
#(
    parameter int INDEX_WIDTH = 16,
    parameter int COORD_WIDTH = 32,
    parameter int ENT_W       = 58
) (
    input  logic             clk,
    input  logic             rst_n,
    ple_prim_if.sink         prim,
    output logic             q_valid,
    input  logic             q_ready,
    output logic [ENT_W-1:0] q_data
);

    logic [INDEX_WIDTH-1:0]      cnt_reg;
    logic [INDEX_WIDTH-1:0]      cnt_next;
    logic [INDEX_WIDTH-1:0]      c_cur;

    logic                        s1_valid_reg;
    logic [MODE_W-1:0]           s1_mode_reg;
    logic [INDEX_WIDTH-1:0]      s1_a_reg;
    logic [INDEX_WIDTH-1:0]      s1_b_reg;
    logic [INDEX_WIDTH-1:0]      s1_c_reg;
    logic signed [COORD_WIDTH:0] s1_dx_reg;
    logic signed [COORD_WIDTH:0] s1_dy_reg;

    logic signed [COORD_WIDTH:0] dx;
    logic signed [COORD_WIDTH:0] dy;
    logic [COORD_WIDTH:0]        abs_dx;
    logic [COORD_WIDTH:0]        abs_dy;
    logic                        horiz;
    logic                        posi;
    logic [POS_W-1:0]            t0;
    logic [POS_W-1:0]            t1;

    logic accept;
    logic s1_drop;
    logic s1_free;

    assign accept  = prim.valid && prim.ready;
    // unused mode code: item retires here without a queue entry
    assign s1_drop = (s1_mode_reg != MODE_TRI) && (s1_mode_reg != MODE_POINT)
                     && (s1_mode_reg != MODE_LINE);
    assign s1_free = !s1_valid_reg || s1_drop || q_ready;
    assign prim.ready = s1_free;
    assign q_valid = s1_valid_reg && !s1_drop;

    assign c_cur = prim.batch_start ? prim.new_vertex_base : cnt_reg;

    always_comb
    begin
        case (mode_t'(prim.mode))
            MODE_POINT: cnt_next = c_cur + INDEX_WIDTH'(3);
            MODE_LINE:  cnt_next = c_cur + INDEX_WIDTH'(2);
            default:    cnt_next = c_cur;
        endcase
    end

    assign dx = {prim.second_x[COORD_WIDTH-1], prim.second_x}
              - {prim.first_x[COORD_WIDTH-1], prim.first_x};
    assign dy = {prim.second_y[COORD_WIDTH-1], prim.second_y}
              - {prim.first_y[COORD_WIDTH-1], prim.first_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                cnt_reg <= cnt_next;
            if (s1_free)
                s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= prim.mode;
            s1_a_reg    <= prim.vert_a;
            s1_b_reg    <= prim.vert_b;
            s1_c_reg    <= c_cur;
            s1_dx_reg   <= dx;
            s1_dy_reg   <= dy;
        end
    end

    // orientation: tie of magnitudes counts as vertical
    assign abs_dx = s1_dx_reg[COORD_WIDTH] ? $unsigned(-s1_dx_reg) : $unsigned(s1_dx_reg);
    assign abs_dy = s1_dy_reg[COORD_WIDTH] ? $unsigned(-s1_dy_reg) : $unsigned(s1_dy_reg);
    assign horiz  = abs_dx > abs_dy;
    assign posi   = horiz ? (!s1_dx_reg[COORD_WIDTH] && (s1_dx_reg != '0))
                          : (!s1_dy_reg[COORD_WIDTH] && (s1_dy_reg != '0));

    always_comb
    begin
        if (horiz)
        begin
            t0 = posi ? POS_DIR_POS_X : POS_DIR_POS_Y;
            t1 = posi ? POS_DIR_POS_Y : POS_DIR_POS_X;
        end
        else
        begin
            t0 = posi ? POS_DIR_NEG_Y : POS_DIR_NEG_X;
            t1 = posi ? POS_DIR_NEG_X : POS_DIR_NEG_Y;
        end
    end

    assign q_data = {s1_mode_reg, t0, t1, s1_a_reg, s1_b_reg, s1_c_reg};

endmodule

// ===== hw/rtl/ple_queue.sv =====
`timescale 1ns / 1ps

module ple_queue #(
    parameter int WIDTH = 58
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam logic [1:0] FULL = 2'd2;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != FULL;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ===== hw/rtl/ple_back.sv =====
`timescale 1ns / 1ps

module ple_back
    import ple_pkg::*;
#(
    parameter int INDEX_WIDTH = 16,
    parameter int ENT_W       = 58
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  logic [ENT_W-1:0] q_data,
    ple_rec_if.source        rec
);

    localparam int IW = INDEX_WIDTH;

    logic                   cur_valid_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [MODE_W-1:0]      cur_mode_reg;
    logic [POS_W-1:0]       cur_t0_reg;
    logic [POS_W-1:0]       cur_t1_reg;
    logic [IW-1:0]          cur_a_reg;
    logic [IW-1:0]          cur_b_reg;
    logic [IW-1:0]          cur_c_reg;

    logic                   out_valid_reg;
    logic [1:0]             out_kind_reg;
    logic [IW-1:0]          out_vidx_reg;
    logic [IW-1:0]          out_src_reg;
    logic [MASK_W-1:0]      out_mask_reg;
    logic [POS_W-1:0]       out_pos_reg;
    logic [TEX_W-1:0]       out_tex_reg;
    logic                   out_last_reg;

    rec_kind_t              r_kind;
    logic [IW-1:0]          r_vidx;
    logic [IW-1:0]          r_src;
    logic [MASK_W-1:0]      r_mask;
    logic [POS_W-1:0]       r_pos;
    logic [TEX_W-1:0]       r_tex;
    logic                   r_last;

    logic [IW-1:0]          c1;
    logic [IW-1:0]          c2;
    logic                   out_free;
    logic                   emit;
    logic                   cur_done;
    logic                   load;

    assign c1 = cur_c_reg + IW'(1);
    assign c2 = cur_c_reg + IW'(2);

    assign out_free = !out_valid_reg || rec.ready;
    assign emit     = cur_valid_reg && out_free;
    assign cur_done = emit && r_last;
    assign q_ready  = !cur_valid_reg || cur_done;
    assign load     = q_valid && q_ready;

    always_comb
    begin
        r_kind = REC_INDEX;
        r_vidx = cur_a_reg;
        r_src  = '0;
        r_mask = '0;
        r_pos  = '0;
        r_tex  = TEX_OFS_NONE;
        r_last = step_reg == LAST_STEP;
        case (mode_t'(cur_mode_reg))
            MODE_POINT:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        r_kind = REC_RETAG;
                        r_mask = TEX_MASK_POINT;
                        r_pos  = POS_CORNER_LT;
                    end
                    4'd1:
                    begin
                        r_kind = REC_COPY;
                        r_vidx = cur_c_reg;
                        r_src  = cur_a_reg;
                        r_mask = TEX_MASK_POINT;
                        r_pos  = POS_CORNER_RT;
                        r_tex  = TEX_OFS_X;
                    end
                    4'd2:
                    begin
                        r_kind = REC_COPY;
                        r_vidx = c1;
                        r_src  = cur_a_reg;
                        r_mask = TEX_MASK_POINT;
                        r_pos  = POS_CORNER_LB;
                        r_tex  = TEX_OFS_Y;
                    end
                    4'd3:
                    begin
                        r_kind = REC_COPY;
                        r_vidx = c2;
                        r_src  = cur_a_reg;
                        r_mask = TEX_MASK_POINT;
                        r_pos  = POS_CORNER_RB;
                        r_tex  = TEX_OFS_XY;
                    end
                    4'd5:    r_vidx = cur_c_reg;
                    4'd6:    r_vidx = c1;
                    4'd7:    r_vidx = c1;
                    4'd8:    r_vidx = cur_c_reg;
                    4'd9:    r_vidx = c2;
                    default: r_vidx = cur_a_reg;
                endcase
            end
            MODE_LINE:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        r_kind = REC_RETAG;
                        r_mask = TEX_MASK_LINE;
                        r_pos  = cur_t0_reg;
                    end
                    4'd1:
                    begin
                        r_kind = REC_RETAG;
                        r_vidx = cur_b_reg;
                        r_mask = TEX_MASK_LINE;
                        r_pos  = cur_t0_reg;
                    end
                    4'd2:
                    begin
                        r_kind = REC_COPY;
                        r_vidx = cur_c_reg;
                        r_src  = cur_a_reg;
                        r_mask = TEX_MASK_LINE;
                        r_pos  = cur_t1_reg;
                        r_tex  = TEX_OFS_LINE;
                    end
                    4'd3:
                    begin
                        r_kind = REC_COPY;
                        r_vidx = c1;
                        r_src  = cur_b_reg;
                        r_mask = TEX_MASK_LINE;
                        r_pos  = cur_t1_reg;
                        r_tex  = TEX_OFS_LINE;
                    end
                    4'd5:    r_vidx = cur_c_reg;
                    4'd6:    r_vidx = c1;
                    4'd7:    r_vidx = c1;
                    4'd8:    r_vidx = cur_b_reg;
                    default: r_vidx = cur_a_reg;
                endcase
            end
            default:
                r_last = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                cur_valid_reg <= 1'b1;
            else if (cur_done)
                cur_valid_reg <= 1'b0;
            if (load)
                step_reg <= '0;
            else if (emit)
                step_reg <= step_reg + STEP_W'(1);
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_mode_reg <= q_data[ENT_W-1 -: MODE_W];
            cur_t0_reg   <= q_data[3*IW+2*POS_W-1 -: POS_W];
            cur_t1_reg   <= q_data[3*IW+POS_W-1 -: POS_W];
            cur_a_reg    <= q_data[3*IW-1 -: IW];
            cur_b_reg    <= q_data[2*IW-1 -: IW];
            cur_c_reg    <= q_data[IW-1:0];
        end
        if (emit)
        begin
            out_kind_reg <= r_kind;
            out_vidx_reg <= r_vidx;
            out_src_reg  <= r_src;
            out_mask_reg <= r_mask;
            out_pos_reg  <= r_pos;
            out_tex_reg  <= r_tex;
            out_last_reg <= r_last;
        end
    end

    assign rec.valid          = out_valid_reg;
    assign rec.record_kind    = out_kind_reg;
    assign rec.vertex_index   = out_vidx_reg;
    assign rec.source_index   = out_src_reg;
    assign rec.tex_mask_tag   = out_mask_reg;
    assign rec.position_tag   = out_pos_reg;
    assign rec.tex_offset_tag = out_tex_reg;
    assign rec.last           = out_last_reg;

endmodule

// ===== hw/rtl/point_line_to_triangle_expander_core.sv =====
// Channel  Dir  Transaction
// -------  ---  ---------------------------------------------------------
// prim     in   one primitive: triangle index, point or line
// rec      out  one record: index, new vertex copy or retag; last on final
//
// Point and line each give ten records, one per cycle while rec is ready; a
// triangle index gives one. An item goes from the front stage register via
// the queue and the emitter's item registers to the record output register.
// Front (counter, dx/dy, orientation) and back (emitter) meet at a two-entry
// queue; either side can stall while the other runs on until it fills or
// empties. Reset is asynchronous; the new-vertex counter clears to zero.
`timescale 1ns / 1ps

module point_line_to_triangle_expander_core
    import ple_pkg::*;
#(
    parameter int INDEX_WIDTH = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ple_prim_if.sink  prim,
    ple_rec_if.source rec
);

    localparam int ENT_W = ent_width(INDEX_WIDTH);

    logic             fq_valid;
    logic             fq_ready;
    logic [ENT_W-1:0] fq_data;
    logic             qb_valid;
    logic             qb_ready;
    logic [ENT_W-1:0] qb_data;

    ple_front #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .ENT_W       (ENT_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .prim    (prim),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    ple_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    ple_back #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .ENT_W       (ENT_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .rec     (rec)
    );

endmodule
